// File: src/sha_pkg.sv
package sha_pkg;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  valid_bytes;
        logic        message_last;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        digest_last;
    } out_beat_t;

    typedef struct packed {
        logic       init_chain;
        logic       clear_len;
        logic       add_len;
        logic       push;
        logic [1:0] push_sel;
        logic       load_work;
        logic       round;
        logic       fold;
        logic       shift_out;
    } sha_cmd_t;

    typedef struct packed {
        logic [3:0] word_pos;
        logic [5:0] round_idx;
    } sha_stat_t;

    localparam logic [1:0] PUSH_DATA = 2'd0;
    localparam logic [1:0] PUSH_PAD  = 2'd1;
    localparam logic [1:0] PUSH_LENH = 2'd2;
    localparam logic [1:0] PUSH_LENL = 2'd3;

    localparam logic [31:0] PAD_WORD = 32'h80000000;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

endpackage

// File: src/sha_datapath.sv
module sha_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  sha_pkg::sha_cmd_t  cmd,
    input  logic [31:0]        data_word,
    input  logic [5:0]         len_add,
    output sha_pkg::sha_stat_t stat,
    output logic [31:0]        digest_word
);

    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [63:0] len_reg;
    logic [3:0]  pos_reg;
    logic [5:0]  rnd_reg;

    logic [31:0] push_word;
    logic [31:0] w15, w2, g0, g1, w_new, w_cur;
    logic [31:0] s1, ch, t1, s0, maj;

    always_comb begin
        unique case (cmd.push_sel)
            sha_pkg::PUSH_DATA: push_word = data_word;
            sha_pkg::PUSH_PAD:  push_word = 32'd0;
            sha_pkg::PUSH_LENH: push_word = len_reg[63:32];
            default:            push_word = len_reg[31:0];
        endcase
        w15 = w_reg[4'(rnd_reg[3:0] - 4'd15)];
        w2 = w_reg[4'(rnd_reg[3:0] - 4'd2)];
        g0 = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
        g1 = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
        w_new = w_reg[rnd_reg[3:0]] + g0 + w_reg[4'(rnd_reg[3:0] - 4'd7)] + g1;
        w_cur = (rnd_reg >= 6'd16) ? w_new : w_reg[rnd_reg[3:0]];
        s1 = {v_reg[4][5:0], v_reg[4][31:6]} ^ {v_reg[4][10:0], v_reg[4][31:11]}
            ^ {v_reg[4][24:0], v_reg[4][31:25]};
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1 = v_reg[7] + s1 + ch + sha_pkg::ROUND_K[rnd_reg] + w_cur;
        s0 = {v_reg[0][1:0], v_reg[0][31:2]} ^ {v_reg[0][12:0], v_reg[0][31:13]}
            ^ {v_reg[0][21:0], v_reg[0][31:22]};
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) h_reg[i] <= sha_pkg::INIT_H[i];
            len_reg <= '0;
            pos_reg <= '0;
            rnd_reg <= '0;
        end else begin
            if (cmd.add_len) len_reg <= len_reg + 64'(len_add);
            if (cmd.clear_len) len_reg <= '0;
            if (cmd.push) begin
                w_reg[pos_reg] <= push_word;
                pos_reg <= pos_reg + 4'd1;
            end
            if (cmd.load_work) begin
                for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                rnd_reg <= '0;
            end
            if (cmd.round) begin
                if (rnd_reg >= 6'd16) w_reg[rnd_reg[3:0]] <= w_new;
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + s0 + maj;
                rnd_reg <= rnd_reg + 6'd1;
            end
            if (cmd.fold) begin
                for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
            end
            if (cmd.shift_out) begin
                for (int i = 0; i < 7; i++) h_reg[i] <= h_reg[i + 1];
                h_reg[7] <= h_reg[0];
            end
            if (cmd.init_chain) begin
                for (int i = 0; i < 8; i++) h_reg[i] <= sha_pkg::INIT_H[i];
                pos_reg <= '0;
            end
        end
    end

    assign stat.word_pos = pos_reg;
    assign stat.round_idx = rnd_reg;
    assign digest_word = h_reg[0];

endmodule

// File: src/sha_control.sv
module sha_control (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sha_pkg::in_beat_t  s_beat,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_last,
    input  sha_pkg::sha_stat_t stat,
    output sha_pkg::sha_cmd_t  cmd,
    output logic [31:0]        data_word,
    output logic [5:0]         len_add
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_PAD80, ST_ZERO, ST_LENH, ST_LENL, ST_ROUND, ST_FOLD, ST_OUT
    } state_t;

    state_t      state_reg;
    logic        final_reg;
    logic        after_reg;
    logic [2:0]  out_cnt_reg;
    logic [2:0]  nb;
    logic [31:0] keep, padded;
    logic        take;

    assign s_ready = (state_reg == ST_IDLE);
    assign take = s_valid && s_ready;
    assign m_valid = (state_reg == ST_OUT);
    assign m_last = (out_cnt_reg == 3'd7);

    always_comb begin
        nb = (s_beat.valid_bytes > 3'd4) ? 3'd4 : s_beat.valid_bytes;
        unique case (nb)
            3'd0:    keep = 32'h0;
            3'd1:    keep = s_beat.data_word & 32'hff000000;
            3'd2:    keep = s_beat.data_word & 32'hffff0000;
            3'd3:    keep = s_beat.data_word & 32'hffffff00;
            default: keep = s_beat.data_word;
        endcase
        padded = keep | (nb == 3'd4 ? 32'd0 : (sha_pkg::PAD_WORD >> {nb, 3'b000}));
        data_word = sha_pkg::PAD_WORD;
        if (state_reg == ST_IDLE) begin
            data_word = s_beat.message_last ? padded : s_beat.data_word;
        end
        len_add = s_beat.message_last ? {nb, 3'b000} : 6'd32;
        cmd = '0;
        cmd.push_sel = sha_pkg::PUSH_DATA;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.push = take;
                cmd.add_len = take;
            end
            ST_PAD80: cmd.push = 1'b1;
            ST_ZERO: begin
                cmd.push = (stat.word_pos != 4'd14);
                cmd.push_sel = sha_pkg::PUSH_PAD;
            end
            ST_LENH: begin
                cmd.push = 1'b1;
                cmd.push_sel = sha_pkg::PUSH_LENH;
            end
            ST_LENL: begin
                cmd.push = 1'b1;
                cmd.push_sel = sha_pkg::PUSH_LENL;
            end
            ST_ROUND: cmd.round = 1'b1;
            ST_FOLD: cmd.fold = 1'b1;
            ST_OUT: begin
                cmd.shift_out = m_ready;
                cmd.init_chain = m_ready && m_last;
                cmd.clear_len = m_ready && m_last;
            end
            default: ;
        endcase
        cmd.load_work = cmd.push && (stat.word_pos == 4'd15);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            final_reg <= 1'b0;
            after_reg <= 1'b0;
            out_cnt_reg <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: if (take) begin
                    final_reg <= s_beat.message_last;
                    if (s_beat.message_last) begin
                        after_reg <= 1'b0;
                        if (stat.word_pos == 4'd15) begin
                            state_reg <= ST_ROUND;
                        end else begin
                            state_reg <= (nb == 3'd4) ? ST_PAD80 : ST_ZERO;
                        end
                        if (nb == 3'd4) after_reg <= 1'b1;
                    end else if (stat.word_pos == 4'd15) begin
                        state_reg <= ST_ROUND;
                    end
                end
                ST_PAD80: begin
                    after_reg <= 1'b0;
                    state_reg <= (stat.word_pos == 4'd15) ? ST_ROUND : ST_ZERO;
                end
                ST_ZERO: begin
                    if (stat.word_pos == 4'd14) state_reg <= ST_LENH;
                    else if (stat.word_pos == 4'd15) state_reg <= ST_ROUND;
                end
                ST_LENH: state_reg <= ST_LENL;
                ST_LENL: begin
                    final_reg <= 1'b0;
                    after_reg <= 1'b1;
                    state_reg <= ST_ROUND;
                end
                ST_ROUND: if (stat.round_idx == 6'd63) state_reg <= ST_FOLD;
                ST_FOLD: begin
                    if (!final_reg && after_reg) begin
                        state_reg <= ST_OUT;
                        out_cnt_reg <= '0;
                    end else if (final_reg && after_reg) begin
                        state_reg <= ST_PAD80;
                    end else if (final_reg) begin
                        state_reg <= ST_ZERO;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_OUT: if (m_ready) begin
                    out_cnt_reg <= out_cnt_reg + 3'd1;
                    if (m_last) begin
                        state_reg <= ST_IDLE;
                        after_reg <= 1'b0;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready) else $error("ready while busy");
    a_round_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROUND && stat.round_idx != 6'd63) |=> (state_reg == ST_ROUND))
        else $error("rounds cut short");
    a_out_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_valid && s_ready)) else $error("output during input");
`endif

endmodule

// File: src/sha256_message_hasher.sv
// SHA-256 message hasher.
// Input beats on s_valid/s_ready carry a 32-bit big-endian word, a byte count
// and a last flag. Result beats on m_valid/m_ready carry the eight digest
// words, H0 first, with digest_last set on H7.
// Words are taken one per cycle while idle; the word that fills a 16-word
// block starts 64 rounds, one per cycle, then the working values are folded
// into the chain value. The single round unit sets the pace: no word is
// taken until the block's rounds and fold are done.
// A last word adds padding and length words, the final block's rounds and
// fold, and another block when the data leaves no room; then the digest is
// shown over eight beats.
// Input is not taken while rounds run or the digest is being delivered.
// When the receiver stalls, the current digest word holds until taken.
// Reset (aresetn low, synchronous) loads the initial hash values and clears
// the length and word count; a beat is taken from the first edge after release.
module sha256_message_hasher (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sha_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sha_pkg::out_beat_t m_data
);

    sha_pkg::sha_cmd_t  cmd;
    sha_pkg::sha_stat_t stat;
    logic [31:0]        word;
    logic [31:0]        digest;
    logic [5:0]         len_add;
    logic               last;

    sha_control u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_beat(s_data), .m_valid(m_valid), .m_ready(m_ready), .m_last(last),
        .stat(stat), .cmd(cmd), .data_word(word), .len_add(len_add)
    );

    sha_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .data_word(word),
        .len_add(len_add), .stat(stat), .digest_word(digest)
    );

    assign m_data = '{digest_word: digest, digest_last: last};

endmodule
